### rtl/core/pmwo_pkg.sv
// Shared types and constants of the phase-modulation wavetable oscillator.
package pmwo_pkg;

	// Default geometry of the waveform store.
	localparam int TABLE_SIZE_DEF = 4096;
	localparam int WAVE_COUNT_DEF = 8;

	// Field widths fixed by the item format.
	localparam int SAMPLE_W = 16;
	localparam int SOR_W    = 32;
	localparam int FREQ_W   = 24;
	localparam int POFF_W   = 20;
	localparam int FRAC_W   = 16;

	// Reset value of the size-over-rate register (unsigned Q4.28).
	localparam logic [SOR_W-1:0] SOR_RESET = 32'd22906492;

	// Depth of the result queue and the width of the credit counter.
	localparam int FIFO_DEPTH = 8;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Item modes.
	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_KEYON  = 2'd1,
		MODE_SAMPLE = 2'd2
	} mode_t;

endpackage

### rtl/core/pm_wavetable_oscillator.sv
// Top level of the phase-modulation wavetable oscillator.
// A sample goes through stage 1, the table read, the blend and the queue.
// Throughput: one item of any mode per cycle unless the input stalls, set by
// the phase accumulator update and the dual-read port of the table memory.
// The input stalls while eight sample results are in flight or queued.
// Reset clears the phase, the wave select, the pipeline and the queue and
// loads the register default; table contents stay undefined until written.
module pm_wavetable_oscillator #(
	parameter int TABLE_SIZE = pmwo_pkg::TABLE_SIZE_DEF,
	parameter int WAVE_COUNT = pmwo_pkg::WAVE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pmwo_pkg::SOR_W-1:0]    size_over_rate,
	// Item channel.
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    mode,
	input  logic [2:0]                    wave,
	input  logic [11:0]                   table_index,
	input  logic signed [15:0]            table_value,
	input  logic signed [pmwo_pkg::FREQ_W-1:0] frequency,
	input  logic signed [pmwo_pkg::POFF_W-1:0] phase_mod,
	// Result channel.
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [pmwo_pkg::SAMPLE_W-1:0] sample
);

	// TABLE_SIZE is a power of two, so the phase wraps in PH_W bits.
	localparam int TABLE_AW = $clog2(TABLE_SIZE);
	localparam int PH_W     = TABLE_AW + pmwo_pkg::FRAC_W;
	localparam int WSEL_W   = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;
	localparam int MEM_DEPTH = WAVE_COUNT * TABLE_SIZE;
	localparam int MEM_AW   = $clog2(MEM_DEPTH);
	localparam int PROD_W   = pmwo_pkg::SOR_W + pmwo_pkg::FREQ_W;
	localparam int INC_SH   = 20;

	// The configuration register takes a write in every cycle.
	logic [pmwo_pkg::SOR_W-1:0] sor_q;
	assign cfg_ready = 1'b1;

	// Credit counter: sample items accepted and not yet delivered. It never
	// exceeds the queue depth, so the queue cannot overflow.
	logic [pmwo_pkg::CNT_W-1:0] cnt_q;
	logic item_acc;
	logic sample_acc;
	logic result_pop;

	assign item_stall = (cnt_q == pmwo_pkg::CNT_W'(pmwo_pkg::FIFO_DEPTH));
	assign item_acc   = item_valid && !item_stall;
	assign sample_acc = item_acc && (mode == pmwo_pkg::MODE_SAMPLE);
	assign result_pop = result_valid && !result_stall;

	// Stage 1 front end: table number modulo WAVE_COUNT by repeated
	// subtraction over the three-bit field, increment magnitude product, and
	// the phase offset scaled by the table size (a shift, wrapped in PH_W).
	logic [2:0] wave_red;
	logic [pmwo_pkg::FREQ_W-1:0] fbits;
	logic [pmwo_pkg::FREQ_W-1:0] fmag;
	logic [PROD_W-1:0] prod;
	logic [PH_W-1:0] off;

	always_comb begin
		wave_red = wave;
		for (int k = 0; k < 7; k++) begin
			if (32'(wave_red) >= WAVE_COUNT) begin
				wave_red = wave_red - 3'(WAVE_COUNT);
			end
		end
	end

	assign fbits = frequency;
	assign fmag  = fbits[pmwo_pkg::FREQ_W-1] ? (~fbits + 1'b1) : fbits;
	assign prod  = PROD_W'(sor_q) * PROD_W'(fmag);
	assign off   = {phase_mod[pmwo_pkg::FRAC_W-1:0], {TABLE_AW{1'b0}}};

	logic                          valid_s1;
	logic [1:0]                    mode_s1;
	logic [WSEL_W-1:0]             wave_s1;
	logic [TABLE_AW-1:0]           idx_s1;
	logic [pmwo_pkg::SAMPLE_W-1:0] value_s1;
	logic                          neg_s1;
	logic [PROD_W-1:0]             prod_s1;
	logic [PH_W-1:0]               off_s1;

	// Stage 2: the phase accumulator and wave select live here, and every
	// table access is issued from this stage, so loads, key-ons and samples
	// act in item order without any forwarding.
	logic [PH_W-1:0]   acc_q;
	logic [WSEL_W-1:0] wsel_q;
	logic [PH_W-1:0]   inc_mag;
	logic [PH_W-1:0]   incr;
	logic [PH_W-1:0]   rd_phase;
	logic [TABLE_AW-1:0] ia;
	logic [TABLE_AW-1:0] ib;
	logic              mem_we;
	logic              mem_re;
	logic [MEM_AW-1:0] waddr;
	logic [MEM_AW-1:0] raddr_a;
	logic [MEM_AW-1:0] raddr_b;

	// Increment is sign(p) * (|p| >> 20), reduced modulo the phase range.
	assign inc_mag  = prod_s1[INC_SH + PH_W - 1:INC_SH];
	assign incr     = neg_s1 ? (~inc_mag + 1'b1) : inc_mag;
	assign rd_phase = acc_q + off_s1;
	assign ia       = rd_phase[PH_W-1:pmwo_pkg::FRAC_W];
	assign ib       = ia + 1'b1;

	assign mem_we  = valid_s1 && (mode_s1 == pmwo_pkg::MODE_LOAD);
	assign mem_re  = valid_s1 && (mode_s1 == pmwo_pkg::MODE_SAMPLE);
	assign waddr   = MEM_AW'({wave_s1, idx_s1});
	assign raddr_a = MEM_AW'({wsel_q, ia});
	assign raddr_b = MEM_AW'({wsel_q, ib});

	// Stage 3: table words come out of the memory registers.
	logic                          valid_s3;
	logic [pmwo_pkg::FRAC_W-1:0]   frac_s3;
	logic [pmwo_pkg::SAMPLE_W-1:0] word_a;
	logic [pmwo_pkg::SAMPLE_W-1:0] word_b;

	// Stage 4 result into the queue.
	logic                          valid_s4;
	logic [pmwo_pkg::SAMPLE_W-1:0] blend_out;
	logic [pmwo_pkg::SAMPLE_W-1:0] queue_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sor_q    <= pmwo_pkg::SOR_RESET;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s3 <= 1'b0;
			acc_q    <= '0;
			wsel_q   <= '0;
		end else begin
			if (cfg_valid) begin
				sor_q <= size_over_rate;
			end
			case ({sample_acc, result_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			valid_s1 <= item_acc;
			valid_s3 <= mem_re;
			if (valid_s1) begin
				case (mode_s1)
					pmwo_pkg::MODE_KEYON: begin
						acc_q  <= '0;
						wsel_q <= wave_s1;
					end
					pmwo_pkg::MODE_SAMPLE: begin
						acc_q <= acc_q + incr;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		wave_s1  <= WSEL_W'(wave_red);
		idx_s1   <= TABLE_AW'(table_index);
		value_s1 <= table_value;
		neg_s1   <= frequency[pmwo_pkg::FREQ_W-1];
		prod_s1  <= prod;
		off_s1   <= off;
		frac_s3  <= rd_phase[pmwo_pkg::FRAC_W-1:0];
	end

	pmwo_wave_ram #(
		.DEPTH (MEM_DEPTH),
		.AW    (MEM_AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr),
		.wdata   (value_s1),
		.re      (mem_re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (word_a),
		.rdata_b (word_b)
	);

	pmwo_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.word_a   (word_a),
		.word_b   (word_b),
		.frac_s3  (frac_s3),
		.valid_s4 (valid_s4),
		.result   (blend_out)
	);

	// The queue parts the pipeline from the result channel, so items keep
	// flowing in while a finished sample waits to be taken.
	pmwo_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s4),
		.push_data (blend_out),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (queue_out)
	);

	assign sample = queue_out;

endmodule

### rtl/core/pmwo_wave_ram.sv
// Waveform table memory: one write port and two registered read ports.
module pmwo_wave_ram #(
	parameter int DEPTH = pmwo_pkg::TABLE_SIZE_DEF * pmwo_pkg::WAVE_COUNT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [pmwo_pkg::SAMPLE_W-1:0] wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr_a,
	input  logic [AW-1:0]                 raddr_b,
	output logic [pmwo_pkg::SAMPLE_W-1:0] rdata_a,
	output logic [pmwo_pkg::SAMPLE_W-1:0] rdata_b
);

	logic [pmwo_pkg::SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### rtl/core/pmwo_blend.sv
// Linear interpolation between two adjacent table words.
module pmwo_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s3,
	input  logic [pmwo_pkg::SAMPLE_W-1:0] word_a,
	input  logic [pmwo_pkg::SAMPLE_W-1:0] word_b,
	input  logic [pmwo_pkg::FRAC_W-1:0]   frac_s3,
	output logic                          valid_s4,
	output logic [pmwo_pkg::SAMPLE_W-1:0] result
);

	localparam int DW = pmwo_pkg::SAMPLE_W + 1;
	localparam int PW = DW + pmwo_pkg::FRAC_W + 1;

	logic signed [DW-1:0] diff;
	logic signed [DW-1:0] frac_sx;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_s4;
	logic [pmwo_pkg::SAMPLE_W-1:0] a_s4;
	logic [DW-1:0] sum;

	// The blend a*(1-f) + b*f is a + (b-a)*f, floored by the arithmetic shift.
	assign diff    = $signed({word_b[pmwo_pkg::SAMPLE_W-1], word_b})
	               - $signed({word_a[pmwo_pkg::SAMPLE_W-1], word_a});
	assign frac_sx = $signed({1'b0, frac_s3});
	assign prod    = PW'(diff) * PW'(frac_sx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= prod;
		a_s4    <= word_a;
	end

	assign sum    = {a_s4[pmwo_pkg::SAMPLE_W-1], a_s4}
	              + DW'(prod_s4[pmwo_pkg::FRAC_W + DW - 1:pmwo_pkg::FRAC_W]);
	assign result = sum[pmwo_pkg::SAMPLE_W-1:0];

endmodule

### rtl/core/pmwo_out_fifo.sv
// Result queue between the blend stage and the output channel.
module pmwo_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [pmwo_pkg::SAMPLE_W-1:0] push_data,
	output logic                          valid,
	input  logic                          stall,
	output logic [pmwo_pkg::SAMPLE_W-1:0] data
);

	// The depth is a power of two, so the pointers wrap on their own.
	localparam int PTR_W = $clog2(pmwo_pkg::FIFO_DEPTH);

	logic [pmwo_pkg::SAMPLE_W-1:0] mem [pmwo_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [pmwo_pkg::CNT_W-1:0] count_q;
	logic pop;

	assign valid = (count_q != '0);
	assign pop   = valid && !stall;
	assign data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/pmwo_checker.sv
// Port-level checker of the oscillator and its bind to the top level.
module pmwo_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input logic [1:0]                    mode,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [pmwo_pkg::SAMPLE_W-1:0] sample
);

	logic [pmwo_pkg::CNT_W-1:0] pend_q;
	logic samp_in;
	logic samp_out;

	assign samp_in  = item_valid && !item_stall && (mode == pmwo_pkg::MODE_SAMPLE);
	assign samp_out = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({samp_in, samp_out})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// No result transaction appears without a sample item behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pend_q != '0))
		else $error("result valid with no sample outstanding");

	// The input never stalls while nothing is outstanding.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == '0) |-> !item_stall)
		else $error("input stalled while idle");

	// A sample taken into an empty block is offered once it has passed the pipeline and the queue.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(samp_in && (pend_q == '0)) |-> ##4 result_valid)
		else $error("sample result late");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(sample)))
		else $error("stalled result changed");

endmodule

bind pm_wavetable_oscillator pmwo_checker u_pmwo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.mode         (mode),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.sample       (sample)
);
